/* rtl/core/binary_morphology_3x3_core_macros.svh */
// ----------------------------------------------------------------------------
// binary morphology assertion macros
// shared concurrent check templates, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_3X3_CORE_MACROS_SVH
`define BINARY_MORPHOLOGY_3X3_CORE_MACROS_SVH

// same-cycle implication
`define BMM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/bmm_pkg.sv */
// ----------------------------------------------------------------------------
// bmm_pkg
// shared codes, widths and the 3x3 neighbour operator for binary morphology
// ----------------------------------------------------------------------------
package bmm_pkg;

	// field widths
	localparam int PIX_W      = 64;
	localparam int ROW_W      = 10;
	localparam int TDATA_W    = 80;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// operation codes
	localparam logic [1:0] MODE_DILATE = 2'd0;
	localparam logic [1:0] MODE_ERODE  = 2'd1;
	localparam logic [1:0] MODE_OPEN   = 2'd2;
	localparam logic [1:0] MODE_CLOSE  = 2'd3;

	// register reset values
	localparam logic [6:0]  WIDTH_RST  = 7'd64;
	localparam logic [10:0] HEIGHT_RST = 11'd1024;

	// control from the register block to both halves
	typedef struct packed {
		logic [1:0] mode;
		logic       restart;
	} bmm_ctrl_t;

	// or of all eight neighbours, absent rows passed as zero
	function automatic logic [PIX_W-1:0] bmm_dilate(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] m,
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] wm
	);
		logic [PIX_W-1:0] v;
		v = a | b;
		return (v | (v << 1) | (v >> 1) | (m << 1) | (m >> 1)) & wm;
	endfunction

	// dilation, or erosion as the dual on inverted pixels
	function automatic logic [PIX_W-1:0] bmm_op(
		input logic             erode,
		input logic [PIX_W-1:0] a,
		input logic             has_a,
		input logic [PIX_W-1:0] m,
		input logic [PIX_W-1:0] b,
		input logic             has_b,
		input logic [PIX_W-1:0] wm
	);
		logic [PIX_W-1:0] na;
		logic [PIX_W-1:0] nb;
		logic [PIX_W-1:0] res;
		if (erode) begin
			na  = has_a ? (~a & wm) : '0;
			nb  = has_b ? (~b & wm) : '0;
			res = ~bmm_dilate(na, ~m & wm, nb, wm) & wm;
		end else begin
			res = bmm_dilate(has_a ? a : '0, m, has_b ? b : '0, wm);
		end
		return res;
	endfunction

endpackage

/* rtl/core/binary_morphology_3x3_core.sv */
// ----------------------------------------------------------------------------
// binary_morphology_3x3_core: 3x3 binary dilation, erosion, opening, closing
// path: results cross the decoupling queue and the output register, at most one result a cycle
// throughput: one row per cycle unless the queue fills; a last row may give more than one result
// reset: control cleared, mode dilation, width 64, height 1024, frame restarts
// ----------------------------------------------------------------------------
`include "binary_morphology_3x3_core_macros.svh"

module binary_morphology_3x3_core
	import bmm_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,      // row_pixels
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,      // out_pixels, out_row
	output logic                  m_tlast,      // frame_last
	output logic [0:0]            m_tuser,      // run_last
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int QW = 2 * MAX_WIDTH + 2 + CW;

	logic [1:0]           mode_q;
	logic [6:0]           frame_width_q;
	logic [10:0]          frame_height_q;

	bmm_ctrl_t            ctrl;
	logic                 restart;
	logic [MAX_WIDTH-1:0] wm;
	logic [CW-1:0]        hm1;
	logic                 q_push;
	logic [QW-1:0]        q_push_data;
	logic                 q_pop;
	logic [QW-1:0]        q_head;
	logic                 q_full;
	logic                 q_empty;
	logic [PIX_W-1:0]     out_pixels;
	logic [ROW_W-1:0]     out_row;
	logic                 run_last;
	logic                 frame_last;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_DILATE;
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q         <= cfg_data[1:0];
				CFG_WIDTH:  frame_width_q  <= cfg_data[6:0];
				CFG_HEIGHT: frame_height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// a write to any listed register restarts the frame
	always_comb begin
		unique case (cfg_index) inside
			CFG_MODE, CFG_WIDTH, CFG_HEIGHT: restart = cfg_we;
			default:                         restart = 1'b0;
		endcase
	end

	assign ctrl.mode    = mode_q;
	assign ctrl.restart = restart;

	// column mask, zero width behaves as one column
	always_comb begin
		for (int j = 0; j < MAX_WIDTH; j++) begin
			wm[j] = (frame_width_q == 7'd0) ? (j == 0) : (j < int'(frame_width_q));
		end
	end

	// index of the last row, height clamped to one..MAX_HEIGHT
	always_comb begin
		if (frame_height_q == 11'd0) begin
			hm1 = '0;
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			hm1 = CW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = CW'(frame_height_q - 11'd1);
		end
	end

	// first stage and input side
	bmm_front #(
		.MW(MAX_WIDTH),
		.CW(CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.wm        (wm),
		.hm1       (hm1),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// decoupling queue
	bmm_queue #(
		.W(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// second stage and output side
	bmm_back #(
		.MW(MAX_WIDTH),
		.CW(CW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.wm         (wm),
		.hm1        (hm1),
		.head_vld   (!q_empty),
		.head       (q_head),
		.pop        (q_pop),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.out_pixels (out_pixels),
		.out_row    (out_row),
		.run_last   (run_last),
		.frame_last (frame_last)
	);

	// output packing
	assign m_tdata    = {(TDATA_W - PIX_W - ROW_W)'(0), out_row, out_pixels};
	assign m_tlast    = frame_last;
	assign m_tuser[0] = run_last;

	// checks
	`BMM_ASSERT_IMPLY(a_pop_nonempty, q_pop, !q_empty, "queue popped while empty")
	`BMM_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "queued entry missing after push")
	`BMM_ASSERT_IMPLY(a_frame_end_run_end, m_tvalid && m_tlast, m_tuser[0],
		"last row of frame is not the last transfer of its input")

endmodule

/* rtl/core/bmm_queue.sv */
// ----------------------------------------------------------------------------
// bmm_queue
// two-entry queue of first-stage results between the front and back halves
// ----------------------------------------------------------------------------
module bmm_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);

	// depth is a power of two so the pointers wrap on their own
	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign head  = mem_q[rd_ptr_q];
	assign full  = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CNTW'(push) - CNTW'(pop);
		end
	end

endmodule

/* rtl/core/bmm_front.sv */
// ----------------------------------------------------------------------------
// bmm_front
// accepts rows, runs the first morphology stage and queues its results
// ----------------------------------------------------------------------------
module bmm_front
	import bmm_pkg::*;
#(
	parameter int MW = 64,
	parameter int CW = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmm_ctrl_t            ctrl,
	input  logic [MW-1:0]        wm,
	input  logic [CW-1:0]        hm1,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIX_W-1:0]     s_tdata,      // row_pixels
	input  logic                 q_full,
	output logic                 push,
	output logic [2*MW+1+CW:0]   push_data
);

	logic [MW-1:0]    above1_q;
	logic [MW-1:0]    mid1_q;
	logic [CW-1:0]    rows_in_q;

	logic             acc;
	logic             erode1;
	logic [MW-1:0]    row;
	logic             a_vld;
	logic             b_vld;
	logic [PIX_W-1:0] a64;
	logic [PIX_W-1:0] b64;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && !q_full;
	assign erode1   = (ctrl.mode == MODE_ERODE) || (ctrl.mode == MODE_OPEN);
	assign row      = s_tdata[MW-1:0] & wm;

	// row above the new one, and the new one itself on the last row
	assign a_vld = (rows_in_q != '0);
	assign b_vld = (rows_in_q >= hm1);
	assign a64   = bmm_op(erode1, PIX_W'(above1_q), rows_in_q > CW'(1), PIX_W'(mid1_q),
		PIX_W'(row), 1'b1, PIX_W'(wm));
	assign b64   = bmm_op(erode1, PIX_W'(mid1_q), a_vld, PIX_W'(row), '0, 1'b0, PIX_W'(wm));

	// queue entry: row count, two valids, two result rows
	assign push      = acc && (a_vld || b_vld);
	assign push_data = {rows_in_q, b_vld, a_vld, b64[MW-1:0], a64[MW-1:0]};

	// row buffers
	always_ff @(posedge clk) begin
		if (acc) begin
			above1_q <= mid1_q;
			mid1_q   <= row;
		end
	end

	// row counter, wraps at the frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_q <= '0;
		end else if (ctrl.restart) begin
			rows_in_q <= '0;
		end else if (acc) begin
			rows_in_q <= b_vld ? '0 : rows_in_q + CW'(1);
		end
	end

endmodule

/* rtl/core/bmm_back.sv */
// ----------------------------------------------------------------------------
// bmm_back
// drains queued rows, runs the second stage in two-pass modes, one result
// per cycle into the output register while it can take one
// ----------------------------------------------------------------------------
module bmm_back
	import bmm_pkg::*;
#(
	parameter int MW = 64,
	parameter int CW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bmm_ctrl_t          ctrl,
	input  logic [MW-1:0]      wm,
	input  logic [CW-1:0]      hm1,
	input  logic               head_vld,
	input  logic [2*MW+1+CW:0] head,
	output logic               pop,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [PIX_W-1:0]   out_pixels,
	output logic [ROW_W-1:0]   out_row,
	output logic               run_last,
	output logic               frame_last
);

	logic [MW-1:0]    above2_q;
	logic [MW-1:0]    mid2_q;
	logic [CW-1:0]    rows_mid_q;
	logic             push_b_q;
	logic             sub_q;
	logic             out_vld_q;
	logic [MW-1:0]    out_pix_q;
	logic [CW-1:0]    out_idx_q;
	logic             run_last_q;

	logic [MW-1:0]    a_pix;
	logic [MW-1:0]    b_pix;
	logic             a_vld;
	logic             b_vld;
	logic [CW-1:0]    r_in;
	logic             two;
	logic             erode2;
	logic             cur_is_b;
	logic [MW-1:0]    cur_row;
	logic [CW-1:0]    cur_idx;
	logic             has0;
	logic             has1;
	logic [PIX_W-1:0] op0;
	logic [PIX_W-1:0] op1;
	logic [CW-1:0]    r2_next;
	logic             more_push;
	logic             first;
	logic             emit;
	logic             finish;
	logic             b_emits;
	logic [MW-1:0]    res_pix;
	logic [CW-1:0]    res_idx;
	logic             ld;
	logic             step;

	// unpack queue entry
	assign a_pix = head[MW-1:0];
	assign b_pix = head[2*MW-1:MW];
	assign a_vld = head[2*MW];
	assign b_vld = head[2*MW+1];
	assign r_in  = head[2*MW+2 +: CW];

	assign two    = (ctrl.mode == MODE_OPEN) || (ctrl.mode == MODE_CLOSE);
	assign erode2 = (ctrl.mode == MODE_CLOSE);

	// current first-stage row of the entry
	assign cur_is_b  = push_b_q || !a_vld;
	assign cur_row   = cur_is_b ? b_pix : a_pix;
	assign cur_idx   = cur_is_b ? r_in : r_in - CW'(1);
	assign more_push = !cur_is_b && b_vld;

	// second stage candidates for this row
	assign has0    = (rows_mid_q != '0);
	assign has1    = (rows_mid_q >= hm1);
	assign op0     = bmm_op(erode2, PIX_W'(above2_q), rows_mid_q > CW'(1), PIX_W'(mid2_q),
		PIX_W'(cur_row), 1'b1, PIX_W'(wm));
	assign op1     = bmm_op(erode2, PIX_W'(mid2_q), has0, PIX_W'(cur_row), '0, 1'b0,
		PIX_W'(wm));
	assign r2_next = has1 ? '0 : rows_mid_q + CW'(1);

	// pick this cycle's result
	always_comb begin
		if (two) begin
			first   = !sub_q && has0;
			emit    = first || has1;
			res_pix = first ? op0[MW-1:0] : op1[MW-1:0];
			res_idx = first ? rows_mid_q - CW'(1) : rows_mid_q;
			finish  = !(first && has1);
			b_emits = (r2_next != '0) || (r2_next >= hm1);
		end else begin
			first   = 1'b0;
			emit    = 1'b1;
			res_pix = cur_row;
			res_idx = cur_idx;
			finish  = 1'b1;
			b_emits = 1'b1;
		end
	end

	// advance when the output register can take a result or none is due
	assign ld   = !out_vld_q || m_tready;
	assign step = head_vld && (ld || !emit);
	assign pop  = step && finish && !more_push;

	// second stage row buffers and result payload
	always_ff @(posedge clk) begin
		if (step && finish && two) begin
			above2_q <= mid2_q;
			mid2_q   <= cur_row;
		end
		if (ld && step && emit) begin
			out_pix_q  <= res_pix;
			out_idx_q  <= res_idx;
			run_last_q <= finish && !(more_push && b_emits);
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_mid_q <= '0;
			push_b_q   <= 1'b0;
			sub_q      <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (ctrl.restart) begin
				rows_mid_q <= '0;
			end else if (step && finish && two) begin
				rows_mid_q <= r2_next;
			end
			if (step) begin
				sub_q <= !finish;
				if (finish) begin
					push_b_q <= more_push;
				end
			end
			if (ld) begin
				out_vld_q <= step && emit;
			end
		end
	end

	assign m_tvalid   = out_vld_q;
	assign out_pixels = PIX_W'(out_pix_q);
	assign out_row    = ROW_W'(out_idx_q);
	assign run_last   = run_last_q;
	assign frame_last = (out_idx_q == hm1);

endmodule

/* sim/binary_morphology_3x3_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3_core_tb
// self-checking bench for the 3x3 binary morphology core: rows stream in with
// random gaps on both sides, a bit-exact row predictor builds the expected
// filtered rows, and mode, width and height are swept between frames
// ----------------------------------------------------------------------------
module binary_morphology_3x3_core_tb;
	import bmm_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int RAND_ROWS     = 386;
	localparam int SETTLE_CYCLES = 8;
	localparam int WMAX          = 64;
	localparam int HMAX          = 1024;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic             run_end;
		logic             frame_end;
	} morph_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;      // row_pixels
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;             // out_pixels, out_row
	logic                  m_tlast;             // frame_last
	logic [0:0]            m_tuser;             // run_last
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of the registers and both row-buffered stages
	logic [1:0]       cur_mode   = MODE_DILATE;
	logic [6:0]       cur_width  = WIDTH_RST;
	logic [10:0]      cur_height = HEIGHT_RST;
	logic [PIX_W-1:0] buf_above [2] = '{default: '0};
	logic [PIX_W-1:0] buf_mid [2]   = '{default: '0};
	int               rows_seen [2] = '{default: 0};

	logic [PIX_W-1:0] row_q [$];
	morph_row_t       filtered_q [$];
	morph_row_t       want;
	int               rows_pending = 0;
	int               err_cnt      = 0;
	int               quiet_cycles = 0;
	int               src_gap      = 0;
	int               sink_gap     = 0;
	bit               idle_on      = 1'b0;

	binary_morphology_3x3_core #(
		.MAX_WIDTH  (WMAX),
		.MAX_HEIGHT (HMAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int active_width();
		int w;
		w = cur_width;
		if (w < 1) w = 1;
		if (w > WMAX) w = WMAX;
		return w;
	endfunction

	function automatic int clamp_height(input int h);
		if (h < 1) return 1;
		if (h > HMAX) return HMAX;
		return h;
	endfunction

	// or over the eight neighbours, missing rows given as zero
	function automatic logic [PIX_W-1:0] neighbour_max(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] m,
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] wm
	);
		logic [PIX_W-1:0] v;
		v = a | b;
		return (v | (v << 1) | (v >> 1) | (m << 1) | (m >> 1)) & wm;
	endfunction

	// dilation, or erosion through the complement
	function automatic logic [PIX_W-1:0] window_filter(
		input logic             erode,
		input logic [PIX_W-1:0] a,
		input logic             has_a,
		input logic [PIX_W-1:0] m,
		input logic [PIX_W-1:0] b,
		input logic             has_b,
		input logic [PIX_W-1:0] wm
	);
		logic [PIX_W-1:0] na;
		logic [PIX_W-1:0] nb;
		if (erode) begin
			na = has_a ? (~a & wm) : '0;
			nb = has_b ? (~b & wm) : '0;
			return ~neighbour_max(na, ~m & wm, nb, wm) & wm;
		end
		return neighbour_max(has_a ? a : '0, m, has_b ? b : '0, wm);
	endfunction

	// one row into stage s, up to two filtered rows out
	task automatic stage_step(
		input  int               s,
		input  logic [PIX_W-1:0] row,
		input  logic             erode,
		input  int               h,
		input  logic [PIX_W-1:0] wm,
		output int               n,
		output logic [PIX_W-1:0] px0,
		output int               ix0,
		output logic [PIX_W-1:0] px1,
		output int               ix1
	);
		int               r;
		logic [PIX_W-1:0] prev;
		logic [PIX_W-1:0] tail;
		r    = rows_seen[s];
		prev = buf_mid[s];
		n    = 0;
		px0  = '0;
		px1  = '0;
		ix0  = 0;
		ix1  = 0;
		if (r >= 1) begin
			px0 = window_filter(erode, buf_above[s], r >= 2, prev, row, 1'b1, wm);
			ix0 = r - 1;
			n   = 1;
		end
		buf_above[s] = prev;
		buf_mid[s]   = row;
		if (r + 1 >= h) begin
			// last row of the frame, nothing below it
			tail = window_filter(erode, prev, r >= 1, row, '0, 1'b0, wm);
			if (n == 0) begin
				px0 = tail;
				ix0 = r;
			end else begin
				px1 = tail;
				ix1 = r;
			end
			n++;
			rows_seen[s] = 0;
		end else begin
			rows_seen[s] = r + 1;
		end
	endtask

	// expected filtered rows for one accepted input row
	task automatic predict_filtered(input logic [PIX_W-1:0] din);
		int               h;
		int               n1;
		int               n2;
		int               nres;
		int               k;
		int               i0;
		int               i1;
		int               j0;
		int               j1;
		int               w;
		logic [PIX_W-1:0] wm;
		logic [PIX_W-1:0] p0;
		logic [PIX_W-1:0] p1;
		logic [PIX_W-1:0] q0;
		logic [PIX_W-1:0] q1;
		logic [PIX_W-1:0] res_px [4];
		int               res_ix [4];
		logic             two_pass;
		logic             erode1;
		logic             erode2;
		morph_row_t       item;
		w        = active_width();
		h        = clamp_height(cur_height);
		wm       = (w >= WMAX) ? '1 : ((64'd1 << w) - 64'd1);
		two_pass = (cur_mode == MODE_OPEN) || (cur_mode == MODE_CLOSE);
		erode1   = (cur_mode == MODE_ERODE) || (cur_mode == MODE_OPEN);
		erode2   = (cur_mode == MODE_CLOSE);
		nres     = 0;
		stage_step(0, din & wm, erode1, h, wm, n1, p0, i0, p1, i1);
		for (k = 0; k < n1; k++) begin
			if (!two_pass) begin
				res_px[nres] = (k == 0) ? p0 : p1;
				res_ix[nres] = (k == 0) ? i0 : i1;
				nres++;
			end else begin
				stage_step(1, (k == 0) ? p0 : p1, erode2, h, wm, n2, q0, j0, q1, j1);
				if (n2 >= 1 && nres < 4) begin
					res_px[nres] = q0;
					res_ix[nres] = j0;
					nres++;
				end
				if (n2 >= 2 && nres < 4) begin
					res_px[nres] = q1;
					res_ix[nres] = j1;
					nres++;
				end
			end
		end
		if (nres > 3) nres = 3;
		for (k = 0; k < nres; k++) begin
			item.pix       = res_px[k];
			item.row       = ROW_W'(res_ix[k]);
			item.run_end   = (k == nres - 1);
			item.frame_end = (res_ix[k] + 1 == h);
			filtered_q.push_back(item);
		end
	endtask

	function automatic int draw_gap();
		return idle_on ? int'($urandom_range(0, 19)) : 0;
	endfunction

	task automatic report(input string msg);
		if (err_cnt < 100) $display("mismatch at %0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	// source side: one row per transfer, random gap after each
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (row_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= row_q.pop_front();
				src_gap = draw_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side: track register writes, check results, predict on row transfers
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			// a write to a listed register restarts the frame
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:   cur_mode   = cfg_data[1:0];
					CFG_WIDTH:  cur_width  = cfg_data[6:0];
					CFG_HEIGHT: cur_height = cfg_data[10:0];
					default:    ;
				endcase
				if (cfg_index != CFG_SPARE) rows_seen = '{default: 0};
			end
			// result transfer against the oldest expected row
			if (m_tvalid && m_tready) begin
				if (filtered_q.size() == 0) begin
					report($sformatf("unexpected result, tdata %h", m_tdata));
				end else begin
					want = filtered_q.pop_front();
					if (m_tdata[PIX_W-1:0] !== want.pix)
						report($sformatf("row %0d pixels %h, expected %h",
							want.row, m_tdata[PIX_W-1:0], want.pix));
					if (m_tdata[PIX_W+ROW_W-1:PIX_W] !== want.row)
						report($sformatf("out_row %0d, expected %0d",
							m_tdata[PIX_W+ROW_W-1:PIX_W], want.row));
					if (m_tdata[TDATA_W-1:PIX_W+ROW_W] !== '0)
						report($sformatf("row %0d padding bits %h", want.row,
							m_tdata[TDATA_W-1:PIX_W+ROW_W]));
					if (m_tuser[0] !== want.run_end)
						report($sformatf("row %0d run_last %b, expected %b",
							want.row, m_tuser[0], want.run_end));
					if (m_tlast !== want.frame_end)
						report($sformatf("row %0d frame_last %b, expected %b",
							want.row, m_tlast, want.frame_end));
				end
				sink_gap = draw_gap();
			end
			// row transfer
			if (s_tvalid && s_tready) begin
				predict_filtered(s_tdata);
				rows_pending--;
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// watchdog on cycles without any transfer
	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	task automatic queue_row(input logic [PIX_W-1:0] px);
		row_q.push_back(px);
		rows_pending++;
	endtask

	// wait for every row to be taken and every result to arrive, then let
	// rows that cause no result clear the pipeline
	task automatic settle();
		while (rows_pending != 0 || filtered_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// all three registers, unused upper data bits of mode and width randomised
	task automatic set_frame(input logic [1:0] md, input logic [6:0] wd, input logic [10:0] ht);
		cfg_write(CFG_MODE, {9'($urandom), md});
		cfg_write(CFG_WIDTH, {4'($urandom), wd});
		cfg_write(CFG_HEIGHT, ht);
	endtask

	function automatic logic [PIX_W-1:0] random_row();
		logic [PIX_W-1:0] a;
		logic [PIX_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return a & b;
			1: return a | b;
			2: return ~(a & b);
			3: return ~(64'd1 << a[5:0]);
			4: return 64'd1 << a[5:0];
			default: return a;
		endcase
	endfunction

	// stimulus
	initial begin
		int         rand_rows;
		int         n;
		int         k;
		int         fh;
		bit         paused;
		logic [1:0] md;
		logic [6:0] wd;
		logic [10:0] ht;
		rand_rows = 0;
		paused    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: dilation, full width, tall frame, back to back
		idle_on = 1'b0;
		queue_row('0);
		queue_row('1);
		queue_row({32{2'b10}});
		queue_row({32{2'b01}});
		queue_row(64'd1);
		queue_row(64'h8000_0000_0000_0000);
		settle();

		// single-row frame, erosion from horizontal neighbours only
		set_frame(MODE_ERODE, 7'd64, 11'd1);
		queue_row('1);
		queue_row('0);
		queue_row(random_row());
		settle();

		// zero width and height act as one, lone pixel has no neighbour
		idle_on = 1'b1;
		set_frame(MODE_DILATE, 7'd0, 11'd0);
		queue_row('1);
		queue_row(64'd1);
		settle();

		// oversized width and height clamp to the maximum
		set_frame(MODE_OPEN, 7'd127, 11'd2047);
		repeat (3) queue_row(random_row());
		settle();

		// closing on a one-pixel column
		set_frame(MODE_CLOSE, 7'd1, 11'd3);
		queue_row(64'd1);
		queue_row('0);
		queue_row('1);
		settle();

		// write to the unused index mid-frame leaves the frame running
		set_frame(MODE_OPEN, 7'd13, 11'd4);
		queue_row(random_row());
		queue_row(random_row());
		settle();
		cfg_write(CFG_SPARE, 11'($urandom));
		queue_row(random_row());
		queue_row(random_row());
		settle();

		// two-row closing
		set_frame(MODE_CLOSE, 7'd64, 11'd2);
		queue_row('1);
		queue_row('0);
		settle();

		// lone pixel under erosion gives one
		set_frame(MODE_ERODE, 7'd1, 11'd1);
		queue_row('0);
		settle();

		// random frames with random settings
		while (rand_rows < RAND_ROWS) begin
			md = 2'($urandom);
			case ($urandom_range(0, 9))
				0:       wd = 7'd0;
				1:       wd = 7'd1;
				2:       wd = 7'd64;
				3:       wd = 7'($urandom_range(65, 127));
				default: wd = 7'($urandom_range(2, 63));
			endcase
			case ($urandom_range(0, 15))
				0:       ht = 11'd0;
				1:       ht = 11'd1;
				2:       ht = 11'd1024;
				3:       ht = 11'($urandom_range(1025, 2047));
				4, 5:    ht = 11'($urandom_range(10, 40));
				default: ht = 11'($urandom_range(2, 9));
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) cfg_write(CFG_SPARE, 11'($urandom));
			set_frame(md, wd, ht);
			fh = clamp_height(ht);
			if (fh <= 40) begin
				n = fh * $urandom_range(1, 3);
				if ($urandom_range(0, 2) == 0) n += $urandom_range(0, fh - 1);
			end else begin
				n = $urandom_range(3, 20);
			end
			// keep the total row count close to the target
			if (n > RAND_ROWS - rand_rows) n = RAND_ROWS - rand_rows;
			for (k = 0; k < n; k++) begin
				queue_row(random_row());
				// source holds off mid-frame until the sink has caught up
				if (!paused && rand_rows > 150 && k == n / 2) begin
					settle();
					paused = 1'b1;
				end
			end
			rand_rows += n;
			settle();
		end

		if (err_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
